FILE: rtl/shr_pkg.sv
// Package for the sequenced history ring: operation codes, default sizes
// and the packed layout of one stored history entry. No dependencies.
package shr_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int REGIONS_DEF = 4;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  typedef struct packed {
    logic [31:0] seq;
    logic [1:0]  region;
    logic [63:0] stamp;
    logic [31:0] text;
  } entry_t;

endpackage

FILE: rtl/sequenced_history_ring_core.sv
// Sequenced history ring: a ring of history entries kept in one synchronous
// memory, with append, remove by sequence, newest-first read and clear.
// Depends on shr_pkg.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+------------------------------------------
// in      | in        | in_valid, in_stall  | func, region, text_handle, completed_at,
//         |           |                     | target_sequence, newest_index
// out     | out       | out_valid, out_stall| ok, entry_seq, entry_region, entry_time,
//         |           |                     | entry_text, evicted_valid, evicted_seq,
//         |           |                     | entry_count
//
// Clear and any rejected operation finish in the decode state; append and read first
// fetch one entry. A remove reads and compares each entry searched, then reads and
// writes each entry shifted down, one step at a time through the memory.
// Reset is synchronous and needs no clearing pass; unheld entries never reach a result.
// A new transfer is taken only when the sequencer is idle; a finished result
// waits in the output register while the next transfer is accepted.
module sequenced_history_ring_core #(
  parameter int DEPTH   = shr_pkg::DEPTH_DEF,
  parameter int REGIONS = shr_pkg::REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [1:0]  region,
  input  logic [31:0] text_handle,
  input  logic [63:0] completed_at,
  input  logic [31:0] target_sequence,
  input  logic [3:0]  newest_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] entry_seq,
  output logic [1:0]  entry_region,
  output logic [63:0] entry_time,
  output logic [31:0] entry_text,
  output logic        evicted_valid,
  output logic [31:0] evicted_seq,
  output logic [4:0]  entry_count
);
  import shr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = (CW > 4) ? CW : 4;
  localparam int RW = 9;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_APP_WR  = 4'd2;
  localparam logic [3:0] S_RD_DATA = 4'd3;
  localparam logic [3:0] S_SR_RD   = 4'd4;
  localparam logic [3:0] S_SR_CMP  = 4'd5;
  localparam logic [3:0] S_SH_RD   = 4'd6;
  localparam logic [3:0] S_SH_WR   = 4'd7;

  logic [3:0]    state, state_next;
  logic [PW-1:0] wslot, wslot_next;
  logic [PW-1:0] cur, cur_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] off, off_next;
  logic [31:0]   nseq, nseq_next;

  logic [1:0]  op_func;
  logic [1:0]  op_region;
  logic [31:0] op_text;
  logic [63:0] op_stamp;
  logic [31:0] op_target;
  logic [3:0]  op_nidx;

  entry_t        mem [DEPTH];
  entry_t        rdata;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  logic        fin, fin_ok, fin_ev;
  logic [31:0] fin_seq, fin_evseq;
  entry_t      fin_entry;

  logic          out_free;
  logic [PW-1:0] cur_inc, wslot_inc, old_slot, rd_slot;
  logic [PW:0]   old_sum, rd_sum;
  logic [CW-1:0] off_inc;
  logic          nidx_ok, region_ok;
  logic [31:0]   nseq_inc;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cur_inc   = (cur == PW'(DEPTH - 1)) ? '0 : cur + 1'b1;
  assign wslot_inc = (wslot == PW'(DEPTH - 1)) ? '0 : wslot + 1'b1;
  assign off_inc   = off + 1'b1;
  assign old_sum   = {1'b0, wslot} + (PW + 1)'(DEPTH) - (PW + 1)'(count);
  assign old_slot  = (old_sum >= (PW + 1)'(DEPTH)) ? PW'(old_sum - (PW + 1)'(DEPTH))
                                                   : PW'(old_sum);
  assign rd_sum    = {1'b0, wslot} + (PW + 1)'(DEPTH - 1) - (PW + 1)'(op_nidx);
  assign rd_slot   = (rd_sum >= (PW + 1)'(DEPTH)) ? PW'(rd_sum - (PW + 1)'(DEPTH))
                                                 : PW'(rd_sum);
  assign nidx_ok   = NW'(op_nidx) < NW'(count);
  assign region_ok = RW'(op_region) < RW'(REGIONS);
  assign nseq_inc  = (nseq == 32'hFFFF_FFFF) ? 32'd1 : nseq + 32'd1;

  always_comb begin
    state_next = state;
    wslot_next = wslot;
    cur_next   = cur;
    count_next = count;
    off_next   = off;
    nseq_next  = nseq;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cur;
    mem_raddr  = cur;
    mem_wdata  = rdata;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_seq    = '0;
    fin_entry  = '0;
    fin_ev     = 1'b0;
    fin_evseq  = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (op_func)
          FUNC_APPEND: begin
            if (region_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = wslot;
              state_next = S_APP_WR;
            end else if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_REMOVE: begin
            if (op_target != 32'd0 && count != '0) begin
              cur_next   = old_slot;
              off_next   = '0;
              state_next = S_SR_RD;
            end else if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_READ: begin
            if (nidx_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = rd_slot;
              state_next = S_RD_DATA;
            end else if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              fin        = 1'b1;
              fin_ok     = 1'b1;
              wslot_next = '0;
              count_next = '0;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_APP_WR: begin
        if (out_free) begin
          mem_we     = 1'b1;
          mem_waddr  = wslot;
          mem_wdata  = '{seq: nseq, region: op_region, stamp: op_stamp, text: op_text};
          fin        = 1'b1;
          fin_ok     = 1'b1;
          fin_seq    = nseq;
          if (count == CW'(DEPTH)) begin
            fin_ev    = 1'b1;
            fin_evseq = rdata.seq;
          end else begin
            count_next = count + 1'b1;
          end
          nseq_next  = nseq_inc;
          wslot_next = wslot_inc;
          state_next = S_IDLE;
        end
      end
      S_RD_DATA: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          fin_seq    = rdata.seq;
          fin_entry  = rdata;
          state_next = S_IDLE;
        end
      end
      S_SR_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = cur;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (rdata.seq == op_target) begin
          state_next = S_SH_RD;
        end else if (off_inc == count) begin
          if (out_free) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cur_next   = cur_inc;
          off_next   = off_inc;
          state_next = S_SR_RD;
        end
      end
      S_SH_RD: begin
        if (off_inc < count) begin
          mem_re     = 1'b1;
          mem_raddr  = cur_inc;
          state_next = S_SH_WR;
        end else if (out_free) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          count_next = count - 1'b1;
          wslot_next = cur;
          state_next = S_IDLE;
        end
      end
      S_SH_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = cur;
        mem_wdata  = rdata;
        cur_next   = cur_inc;
        off_next   = off_inc;
        state_next = S_SH_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wslot <= '0;
      count <= '0;
      nseq  <= 32'd1;
      cur   <= '0;
      off   <= '0;
    end else begin
      state <= state_next;
      wslot <= wslot_next;
      count <= count_next;
      nseq  <= nseq_next;
      cur   <= cur_next;
      off   <= off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_func   <= func;
      op_region <= region;
      op_text   <= text_handle;
      op_stamp  <= completed_at;
      op_target <= target_sequence;
      op_nidx   <= newest_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      ok            <= fin_ok;
      entry_seq     <= fin_seq;
      entry_region  <= fin_entry.region;
      entry_time    <= fin_entry.stamp;
      entry_text    <= fin_entry.text;
      evicted_valid <= fin_ev;
      evicted_seq   <= fin_evseq;
      entry_count   <= 5'(count_next);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("held count exceeds the ring depth");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    nseq != 32'd0)
    else $error("next sequence number is zero");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_DEC)
    else $error("accepted transfer was not decoded in the next cycle");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> off_inc < count)
    else $error("shift step runs past the newest entry");

  a_count_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count == 5'(count))
    else $error("reported count differs from the held count");
`endif

endmodule

FILE: sim/tb_sequenced_history_ring_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequenced_history_ring_core: a directed table and then random
// append, remove, read and clear transfers, checked against a predictor of the ring.
// Depends on shr_pkg and the core RTL.
module tb_sequenced_history_ring_core;
  import shr_pkg::*;

  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  region;
    logic [31:0] text;
    logic [63:0] stamp;
    logic [31:0] target;
    logic [3:0]  nidx;
  } hist_op_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] seq;
    logic [1:0]  region;
    logic [63:0] stamp;
    logic [31:0] text;
    logic        ev_valid;
    logic [31:0] ev_seq;
    logic [4:0]  count;
  } hist_res_t;

  typedef struct {
    hist_op_t  op;
    int        reps;
    bit        typed;
    hist_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [1:0]  region;
  logic [31:0] text_handle;
  logic [63:0] completed_at;
  logic [31:0] target_sequence;
  logic [3:0]  newest_index;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [31:0] entry_seq;
  logic [1:0]  entry_region;
  logic [63:0] entry_time;
  logic [31:0] entry_text;
  logic        evicted_valid;
  logic [31:0] evicted_seq;
  logic [4:0]  entry_count;

  logic [31:0] ring_seq[16];
  logic [1:0]  ring_region[16];
  logic [63:0] ring_stamp[16];
  logic [31:0] ring_text[16];
  logic [3:0]  ring_wr;
  logic [4:0]  ring_count;
  logic [31:0] ring_next;

  hist_res_t ring_expect[$];
  hist_res_t want_res;
  dir_row_t  dir_rows[$];
  bit        no_gaps = 1'b0;
  int        errors = 0;
  int        results_seen = 0;
  int        n_append = 0, n_evict = 0, n_remove = 0, n_found = 0;
  int        n_read = 0, n_hit = 0, n_clear = 0;

  sequenced_history_ring_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .region(region), .text_handle(text_handle), .completed_at(completed_at),
    .target_sequence(target_sequence), .newest_index(newest_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .entry_seq(entry_seq), .entry_region(entry_region), .entry_time(entry_time),
    .entry_text(entry_text), .evicted_valid(evicted_valid), .evicted_seq(evicted_seq),
    .entry_count(entry_count)
  );

  always #1 clk = ~clk;

  function automatic hist_op_t mk_op(logic [1:0] f, logic [1:0] rg, logic [31:0] tx,
                                     logic [63:0] st, logic [31:0] tg, logic [3:0] ix);
    hist_op_t op;
    op = '{func: f, region: rg, text: tx, stamp: st, target: tg, nidx: ix};
    return op;
  endfunction

  function automatic hist_res_t mk_res(logic k, logic [31:0] sq, logic [1:0] rg,
                                       logic [63:0] st, logic [31:0] tx, logic ev,
                                       logic [31:0] es, logic [4:0] cnt);
    hist_res_t r;
    r = '{ok: k, seq: sq, region: rg, stamp: st, text: tx, ev_valid: ev, ev_seq: es,
          count: cnt};
    return r;
  endfunction

  function automatic void ring_wipe();
    for (int i = 0; i < 16; i++) begin
      ring_seq[i] = '0;
      ring_region[i] = '0;
      ring_stamp[i] = '0;
      ring_text[i] = '0;
    end
    ring_wr = '0;
    ring_count = '0;
  endfunction

  function automatic hist_res_t ring_apply(hist_op_t op);
    hist_res_t   r;
    logic [3:0]  old;
    logic [3:0]  d;
    int          hit;
    r = '0;
    old = ring_wr - ring_count[3:0];
    hit = -1;
    case (op.func)
      FUNC_APPEND: begin
        if (op.region < REGIONS_DEF) begin
          if (ring_count == 5'd16) begin
            r.ev_valid = 1'b1;
            r.ev_seq = ring_seq[ring_wr];
          end
          ring_seq[ring_wr] = ring_next;
          ring_region[ring_wr] = op.region;
          ring_stamp[ring_wr] = op.stamp;
          ring_text[ring_wr] = op.text;
          r.ok = 1'b1;
          r.seq = ring_next;
          ring_next = ring_next + 32'd1;
          if (ring_next == '0) ring_next = 32'd1;
          ring_wr = ring_wr + 4'd1;
          if (ring_count < 5'd16) ring_count = ring_count + 5'd1;
        end
      end
      FUNC_REMOVE: begin
        if (op.target != '0) begin
          for (int i = 0; i < ring_count; i++) begin
            if (hit < 0 && ring_seq[4'(old + 4'(i))] == op.target) hit = i;
          end
        end
        if (hit >= 0) begin
          for (int i = hit; i + 1 < ring_count; i++) begin
            d = 4'(old + 4'(i));
            ring_seq[d] = ring_seq[4'(d + 4'd1)];
            ring_region[d] = ring_region[4'(d + 4'd1)];
            ring_stamp[d] = ring_stamp[4'(d + 4'd1)];
            ring_text[d] = ring_text[4'(d + 4'd1)];
          end
          d = 4'(old + ring_count[3:0] - 4'd1);
          ring_seq[d] = '0;
          ring_region[d] = '0;
          ring_stamp[d] = '0;
          ring_text[d] = '0;
          ring_count = ring_count - 5'd1;
          ring_wr = d;
          r.ok = 1'b1;
        end
      end
      FUNC_READ: begin
        if ({1'b0, op.nidx} < ring_count) begin
          d = ring_wr - 4'd1 - op.nidx;
          r.ok = 1'b1;
          r.seq = ring_seq[d];
          r.region = ring_region[d];
          r.stamp = ring_stamp[d];
          r.text = ring_text[d];
        end
      end
      default: begin
        ring_wipe();
        r.ok = 1'b1;
      end
    endcase
    r.count = ring_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_op(hist_op_t op, bit typed, hist_res_t want);
    hist_res_t pred;
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func <= op.func;
    region <= op.region;
    text_handle <= op.text;
    completed_at <= op.stamp;
    target_sequence <= op.target;
    newest_index <= op.nidx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = ring_apply(op);
    case (op.func)
      FUNC_APPEND: begin
        n_append++;
        if (pred.ev_valid) n_evict++;
      end
      FUNC_REMOVE: begin
        n_remove++;
        if (pred.ok) n_found++;
      end
      FUNC_READ: begin
        n_read++;
        if (pred.ok) n_hit++;
      end
      default: n_clear++;
    endcase
    ring_expect.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic row(hist_op_t op, int reps, bit typed, hist_res_t res);
    dir_rows.push_back('{op: op, reps: reps, typed: typed, res: res});
  endtask

  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (ring_expect.size() == 0) begin
        report_mismatch("unexpected result, count", 64'(entry_count), '0);
      end else begin
        want_res = ring_expect.pop_front();
        if (ok !== want_res.ok) report_mismatch("ok", 64'(ok), 64'(want_res.ok));
        if (entry_seq !== want_res.seq)
          report_mismatch("entry_seq", 64'(entry_seq), 64'(want_res.seq));
        if (entry_region !== want_res.region)
          report_mismatch("entry_region", 64'(entry_region), 64'(want_res.region));
        if (entry_time !== want_res.stamp)
          report_mismatch("entry_time", entry_time, want_res.stamp);
        if (entry_text !== want_res.text)
          report_mismatch("entry_text", 64'(entry_text), 64'(want_res.text));
        if (evicted_valid !== want_res.ev_valid)
          report_mismatch("evicted_valid", 64'(evicted_valid), 64'(want_res.ev_valid));
        if (evicted_seq !== want_res.ev_seq)
          report_mismatch("evicted_seq", 64'(evicted_seq), 64'(want_res.ev_seq));
        if (entry_count !== want_res.count)
          report_mismatch("entry_count", 64'(entry_count), 64'(want_res.count));
      end
      results_seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", ring_expect.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    hist_op_t    op;
    int          pick;
    int          sel;
    logic [3:0]  old;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    func = FUNC_READ;
    region = '0;
    text_handle = '0;
    completed_at = '0;
    target_sequence = '0;
    newest_index = '0;
    ring_wipe();
    ring_next = 32'd1;

    row(mk_op(FUNC_READ, 0, 0, 0, 0, 0), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 5, 0), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    row(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0), 1, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 0));
    row(mk_op(FUNC_APPEND, 0, 0, 0, 0, 0), 1, 1, mk_res(1, 1, 0, 0, 0, 0, 0, 1));
    row(mk_op(FUNC_APPEND, 3, '1, ALL1, 0, 0), 1, 1, mk_res(1, 2, 0, 0, 0, 0, 0, 2));
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 0), 1, 1, mk_res(1, 2, 3, ALL1, '1, 0, 0, 2));
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 1), 1, 1, mk_res(1, 1, 0, 0, 0, 0, 0, 2));
    row(mk_op(FUNC_READ, 3, '1, ALL1, '1, 15), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 2));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 0, 0), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 2));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, '1, 0), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 2));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 1, 0), 1, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 1));
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 0), 1, 1, mk_res(1, 2, 3, ALL1, '1, 0, 0, 1));
    row(mk_op(FUNC_APPEND, 1, 32'h5A5A_5A5A, 64'h0123_4567_89AB_CDEF, 0, 0), 15, 0, '0);
    row(mk_op(FUNC_APPEND, 2, 32'hA5A5_A5A5, 64'hFEDC_BA98_7654_3210, 0, 0), 1, 1,
        mk_res(1, 18, 0, 0, 0, 1, 2, 16));
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 15), 1, 0, '0);
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 10, 0), 1, 0, '0);
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 15), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 15));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 3, 0), 1, 0, '0);
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 18, 0), 1, 0, '0);
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 0), 1, 0, '0);
    row(mk_op(FUNC_APPEND, 2, 32'h0000_FFFF, 64'hFFFF_FFFF_0000_0000, 0, 0), 3, 0, '0);
    row(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0), 1, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 0));
    row(mk_op(FUNC_READ, 0, 0, 0, 0, 0), 1, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    row(mk_op(FUNC_APPEND, 3, 1, 1, 0, 0), 1, 1, mk_res(1, 22, 0, 0, 0, 0, 0, 1));
    row(mk_op(FUNC_REMOVE, 0, 0, 0, 22, 0), 1, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) push_op(dir_rows[i].op, dir_rows[i].typed,
                                                         dir_rows[i].res);
    end

    // Random part: appends outweigh removes so the ring often fills and evicts, while
    // rare clears bring it back to empty.
    for (int n = 0; n < 1100; n++) begin
      no_gaps = (n >= 300 && n < 550);
      if (n == 700) begin
        in_valid <= 1'b0;
        while (ring_expect.size() != 0) @(negedge clk);
      end
      op = mk_op(FUNC_APPEND, 2'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                 4'($urandom));
      pick = $urandom_range(0, 999);
      old = ring_wr - ring_count[3:0];
      if (pick < 8) begin
        op.func = FUNC_CLEAR;
      end else if (pick < 500) begin
        op.func = FUNC_APPEND;
      end else if (pick < 760) begin
        op.func = FUNC_REMOVE;
        sel = $urandom_range(0, 9);
        if (sel < 7 && ring_count != 0)
          op.target = ring_seq[4'(old + 4'($urandom_range(0, ring_count - 1)))];
        else if (sel == 7)
          op.target = '0;
        else if (sel == 8)
          op.target = ring_next;
      end else begin
        op.func = FUNC_READ;
        if ($urandom_range(0, 4) != 0 && ring_count != 0)
          op.nidx = 4'($urandom_range(0, ring_count - 1));
      end
      push_op(op, 1'b0, '0);
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    while (ring_expect.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (ring_expect.size() != 0)
      report_mismatch("results never delivered", 64'(ring_expect.size()), '0);

    $display("covered %0d transfers: %0d appends (%0d evicting), %0d removes (%0d found),",
             results_seen, n_append, n_evict, n_remove, n_found);
    $display("%0d reads (%0d in range) and %0d clears; %0d mismatches",
             n_read, n_hit, n_clear, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
